### rtl/dcfb_pkg.sv
// dcfb_pkg: shared types, constants and tables of the dsp command frame builder
// holds the micro-op enum, the control word type, the control store and the crc step
// no dependencies
package dcfb_pkg;

  // command modes
  localparam logic [2:0] MODE_SET_EFFECT  = 3'd0;
  localparam logic [2:0] MODE_STEP_EFFECT = 3'd1;
  localparam logic [2:0] MODE_SET_PRESET  = 3'd2;
  localparam logic [2:0] MODE_SET_BAND    = 3'd3;
  localparam logic [2:0] MODE_STEP_BAND   = 3'd4;
  localparam logic [2:0] MODE_VOLUME      = 3'd5;

  // frame opcodes and fixed bytes
  localparam logic [7:0] OPC_EFFECT = 8'h01;
  localparam logic [7:0] OPC_VOLUME = 8'h02;
  localparam logic [7:0] OPC_PRESET = 8'h04;
  localparam logic [7:0] OPC_BAND   = 8'h06;
  localparam logic [7:0] SUB_WRITE  = 8'h04;
  localparam logic [7:0] BAND_Q     = 8'd10;
  localparam logic [7:0] BAND_CH    = 8'h01;

  localparam logic [2:0] EFFECT_MAX = 3'd5;
  localparam logic [2:0] CHAN_MAX   = 3'd4;
  localparam logic signed [3:0] LVL_MAX = 4'sd7;
  localparam logic signed [3:0] LVL_MIN = -4'sd7;
  localparam logic [3:0] LVL_BIAS   = 4'd7;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // volume scaling
  localparam int          QUOT_W       = 13;
  localparam logic [QUOT_W-1:0] FULL_SCALE = 13'd4096;
  localparam logic [7:0]  MAX_VOL_RESET = 8'd16;
  localparam logic [QUOT_W-1:0] QUOT_RESET = 13'd256;

  localparam int FRAME_DATA_LEN = 6;

  // sequencer
  localparam int         PC_W     = 4;
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_BUILD = 4'd1;
  localparam logic [PC_W-1:0] PC_EMIT0 = 4'd2;

  localparam logic [2:0] SEL_CRC_LO = 3'd6;
  localparam logic [2:0] SEL_CRC_HI = 3'd7;

  typedef enum logic [1:0] {
    UOP_WAIT,
    UOP_BUILD,
    UOP_EMIT
  } uop_e;

  typedef struct packed {
    uop_e            op;
    logic [2:0]      sel;
    logic            crc_en;
    logic            last;
    logic [PC_W-1:0] nxt;
    logic [PC_W-1:0] alt;
  } ucode_t;

  // control store: wait, build, then eight emit steps
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w.op     = UOP_WAIT;
    w.sel    = 3'd0;
    w.crc_en = 1'b0;
    w.last   = 1'b0;
    w.nxt    = PC_IDLE;
    w.alt    = PC_IDLE;
    case (pc)
      4'd0: begin
        w.op  = UOP_WAIT;
        w.nxt = PC_BUILD;
      end
      4'd1: begin
        w.op  = UOP_BUILD;
        w.nxt = PC_EMIT0;
        w.alt = PC_IDLE;
      end
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
        w.op     = UOP_EMIT;
        w.sel    = 3'(pc - PC_EMIT0);
        w.crc_en = 1'b1;
        w.nxt    = pc + 4'd1;
      end
      4'd8: begin
        w.op  = UOP_EMIT;
        w.sel = SEL_CRC_LO;
        w.nxt = 4'd9;
      end
      4'd9: begin
        w.op   = UOP_EMIT;
        w.sel  = SEL_CRC_HI;
        w.last = 1'b1;
        w.nxt  = PC_IDLE;
      end
      default: begin
        w.op  = UOP_WAIT;
        w.nxt = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  // band gain by biased level
  function automatic logic [15:0] gain_lut(input logic [3:0] idx);
    logic [15:0] g;
    case (idx)
      4'd0:    g = 16'd200;
      4'd1:    g = 16'd210;
      4'd2:    g = 16'd220;
      4'd3:    g = 16'd240;
      4'd4:    g = 16'd260;
      4'd5:    g = 16'd280;
      4'd6:    g = 16'd300;
      4'd7:    g = 16'd320;
      4'd8:    g = 16'd340;
      4'd9:    g = 16'd360;
      4'd10:   g = 16'd380;
      4'd11:   g = 16'd400;
      4'd12:   g = 16'd420;
      4'd13:   g = 16'd430;
      4'd14:   g = 16'd440;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

  // one byte through the reflected crc
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/dsp_command_frame_builder.sv
// dsp_command_frame_builder: turns one audio-dsp command into an 8-byte crc-protected frame
// usage:
//   input channel (in_valid_i/in_ready_o) takes one command per transfer: mode, value,
//   direction, band, level, channel. output channel (out_valid_o/out_ready_i) gives the
//   frame one byte per transfer, bytes 0..5 then crc-16/modbus low and high, last_o on
//   the eighth, with effect_now_o and band_level_now_o as they stand after the command.
//   a rejected command gives no bytes and changes no state.
// timing:
//   a microcoded sequencer runs wait, build and eight emit steps from its control store.
//   the build step follows the input transfer, then each emit step loads one byte into the
//   output register, one byte per cycle while the receiver takes them; a rejected command
//   returns from the build step to wait. the crc is folded in one byte per data emit step.
// config: max_volume at byte address 0 over the apb port. a write restarts the volume
//   step divider, which holds in_ready_o low while it runs.
// reset: max_volume 16, effect mode 0, all band levels 0, no clearing pass; the input
//   is ready in the first cycle after reset.
// stall: a stalled receiver holds the byte in the output register and freezes the
//   sequencer on that emit step; nothing is dropped.
// depends on dcfb_pkg and dcfb_div
module dsp_command_frame_builder
  import dcfb_pkg::*;
#(
  parameter int NUM_BANDS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        value_i,
  input  logic              direction_i,
  input  logic [2:0]        band_i,
  input  logic signed [3:0] level_i,
  input  logic [2:0]        channel_i,
  // frame output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic              last_o,
  output logic [2:0]        effect_now_o,
  output logic signed [3:0] band_level_now_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int BIDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int BAND_X_W = (BIDX_W > 3) ? BIDX_W : 3;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;
  logic            in_fire, emit_go, cmd_ok;

  // command latch
  logic [2:0]        mode_q, band_q, channel_q;
  logic [7:0]        value_q;
  logic              dir_q;
  logic signed [3:0] level_q;

  // state
  logic [7:0]        max_vol_q;
  logic [2:0]        eff_q;
  logic signed [3:0] band_lvl_q [NUM_BANDS];

  // frame datapath
  logic [7:0]        b_q [FRAME_DATA_LEN];
  logic [7:0]        b_d [FRAME_DATA_LEN];
  logic [15:0]       crc_q;
  logic [2:0]        eff_now_q, eff_now_d;
  logic signed [3:0] lvl_now_q, lvl_now_d;
  logic [7:0]        emit_byte;

  // output register
  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [2:0]        out_eff_q;
  logic signed [3:0] out_lvl_q;

  // divider link
  logic              cfg_wr, div_busy;
  logic [QUOT_W-1:0] quot;

  // build-step helpers
  logic [BAND_X_W-1:0] band_x;
  logic [BIDX_W-1:0]   bidx;
  logic                band_ok;
  logic signed [3:0]   cur_lvl, step_lvl, used_lvl;
  logic [2:0]          step_eff;
  logic [15:0]         band_gain, vol_gain;
  logic [20:0]         vol_prod;

  assign uc = ucode_rom(pc_q);

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, max_vol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vol_q <= MAX_VOL_RESET;
    end else if (cfg_wr) begin
      max_vol_q <= pwdata[7:0];
    end
  end

  dcfb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_wr),
    .divisor_i (pwdata[7:0]),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  // handshakes
  assign in_ready_o = (uc.op == UOP_WAIT) && !div_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_go    = (uc.op == UOP_EMIT) && (!out_valid_q || out_ready_i);

  // band addressing
  assign band_x  = BAND_X_W'(band_q);
  assign bidx    = band_x[BIDX_W-1:0];
  assign band_ok = (32'(band_q) < NUM_BANDS);
  assign cur_lvl = band_ok ? band_lvl_q[bidx] : 4'sd0;

  // saturating band step and wrapping effect step
  always_comb begin
    step_lvl = cur_lvl;
    if (dir_q) begin
      if (cur_lvl < LVL_MAX) step_lvl = cur_lvl + 4'sd1;
    end else begin
      if (cur_lvl > LVL_MIN) step_lvl = cur_lvl - 4'sd1;
    end
    if (dir_q) begin
      step_eff = (eff_q >= EFFECT_MAX) ? 3'd0 : eff_q + 3'd1;
    end else begin
      step_eff = (eff_q == 3'd0) ? EFFECT_MAX : eff_q - 3'd1;
    end
  end

  assign used_lvl  = (mode_q == MODE_STEP_BAND) ? step_lvl : level_q;
  assign band_gain = gain_lut($unsigned(used_lvl) + LVL_BIAS);
  assign vol_prod  = {8'd0, quot} * {13'd0, value_q};
  assign vol_gain  = (value_q == max_vol_q) ? 16'(FULL_SCALE) : vol_prod[15:0];

  // frame bytes and validity per mode
  always_comb begin
    cmd_ok = 1'b0;
    for (int i = 0; i < FRAME_DATA_LEN; i++) begin
      b_d[i] = 8'd0;
    end
    case (mode_q)
      MODE_SET_EFFECT: begin
        cmd_ok = (value_q <= {5'd0, EFFECT_MAX});
        b_d[0] = OPC_EFFECT;
        b_d[1] = SUB_WRITE;
        b_d[5] = value_q;
      end
      MODE_STEP_EFFECT: begin
        cmd_ok = 1'b1;
        b_d[0] = OPC_EFFECT;
        b_d[1] = SUB_WRITE;
        b_d[5] = {5'd0, step_eff};
      end
      MODE_SET_PRESET: begin
        cmd_ok = 1'b1;
        b_d[0] = OPC_PRESET;
        b_d[1] = SUB_WRITE;
        b_d[5] = value_q;
      end
      MODE_SET_BAND, MODE_STEP_BAND: begin
        cmd_ok = band_ok && ((mode_q == MODE_STEP_BAND) || (level_q != -4'sd8));
        b_d[0] = OPC_BAND;
        b_d[1] = band_gain[15:8];
        b_d[2] = band_gain[7:0];
        b_d[3] = BAND_Q;
        b_d[4] = BAND_CH;
        b_d[5] = {5'd0, band_q};
      end
      MODE_VOLUME: begin
        cmd_ok = (channel_q != 3'd0) && (channel_q <= CHAN_MAX) &&
                 (max_vol_q != 8'd0) && (value_q <= max_vol_q);
        b_d[0] = OPC_VOLUME;
        b_d[1] = SUB_WRITE;
        b_d[3] = {5'd0, channel_q} + 8'd1;
        b_d[4] = vol_gain[15:8];
        b_d[5] = vol_gain[7:0];
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // status as it stands after the command
  assign eff_now_d = (mode_q == MODE_STEP_EFFECT) ? step_eff : eff_q;
  assign lvl_now_d = !band_ok ? 4'sd0 :
                     (mode_q == MODE_STEP_BAND) ? step_lvl : cur_lvl;

  // sequencer step
  always_comb begin
    pc_d = pc_q;
    case (uc.op)
      UOP_WAIT:  if (in_fire) pc_d = uc.nxt;
      UOP_BUILD: pc_d = cmd_ok ? uc.nxt : uc.alt;
      UOP_EMIT:  if (emit_go) pc_d = uc.nxt;
      default:   pc_d = PC_IDLE;
    endcase
  end

  // emit byte select
  always_comb begin
    case (uc.sel)
      SEL_CRC_LO: emit_byte = crc_q[7:0];
      SEL_CRC_HI: emit_byte = crc_q[15:8];
      default:    emit_byte = b_q[uc.sel];
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      eff_q       <= 3'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_lvl_q[i] <= 4'sd0;
      end
    end else begin
      pc_q <= pc_d;
      if (uc.op == UOP_BUILD && cmd_ok) begin
        eff_q <= eff_now_d;
        if (mode_q == MODE_STEP_BAND) begin
          band_lvl_q[bidx] <= step_lvl;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command latch, frame bytes, crc and output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= mode_i;
      value_q   <= value_i;
      dir_q     <= direction_i;
      band_q    <= band_i;
      level_q   <= level_i;
      channel_q <= channel_i;
    end
    if (uc.op == UOP_BUILD) begin
      b_q       <= b_d;
      crc_q     <= CRC_INIT;
      eff_now_q <= eff_now_d;
      lvl_now_q <= lvl_now_d;
    end else if (emit_go && uc.crc_en) begin
      crc_q <= crc_byte(crc_q, emit_byte);
    end
    if (emit_go) begin
      byte_q    <= emit_byte;
      last_q    <= uc.last;
      out_eff_q <= eff_now_q;
      out_lvl_q <= lvl_now_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_byte_o     = byte_q;
  assign last_o           = last_q;
  assign effect_now_o     = out_eff_q;
  assign band_level_now_o = out_lvl_q;

  // an accepted command always goes to the build step
  a_accept_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pc_q == PC_BUILD))
    else $error("accepted command did not reach the build step");

  // no command is taken while the volume step divider runs
  a_div_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_ready_o)
    else $error("input ready while divider busy");

  // loading the final emit step shows last on the output
  a_last_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && uc.last) |=> (out_valid_o && last_o))
    else $error("last byte not marked");

  // a reported band level never leaves -7..7 (stored levels only change by the saturating step)
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (band_level_now_o != -4'sd8))
    else $error("band level out of range");

  // a frame only starts after a build that accepted the command
  a_emit_after_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_EMIT0) |-> ($past(pc_q) == PC_BUILD || $past(pc_q) == PC_EMIT0))
    else $error("emit started without build");

endmodule

### rtl/dcfb_div.sv
// dcfb_div: restoring divider for the full-scale volume step, one quotient bit per cycle
// computes 4096 div divisor after start
// depends on dcfb_pkg
module dcfb_div
  import dcfb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        divisor_i,
  output logic              busy_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        dvs_q, dvs_d;
  logic [7:0]        rem_q, rem_d;
  logic [QUOT_W-1:0] dvd_q, dvd_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [8:0]        shifted;
  logic              fits;

  // trial subtract of the shifted remainder
  assign shifted = {rem_q, dvd_q[QUOT_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'(QUOT_W - 1);
      dvs_d  = divisor_i;
      rem_d  = 8'd0;
      dvd_d  = FULL_SCALE;
    end else if (busy_q) begin
      rem_d = fits ? 8'(shifted - {1'b0, dvs_q}) : shifted[7:0];
      dvd_d = {dvd_q[QUOT_W-2:0], 1'b0};
      quo_d = {quo_q[QUOT_W-2:0], fits};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  // control and quotient reset, working registers free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
      quo_q  <= QUOT_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule
